@@ design/assert_macros.svh @@
// Assertion macros shared by the sorted binary search RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define SBS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sorted binary search: assertion failed");
// Implication: antecedent now, consequent at the next edge.
`define SBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted binary search: sequencing assertion failed");
`else
`define SBS_ASSERT(lbl, clk, rst_n, prop)
`define SBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/sbs_pkg.sv @@
// Shared types and constants for the sorted binary search block.
// Used by every module of the block except sbs_ram; depends on nothing.
`timescale 1ns / 1ps

package sbs_pkg;

  // Store capacity and derived widths.
  localparam int unsigned MAX_ELEMENTS = 256;
  localparam int unsigned ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W = 9;
  localparam int unsigned CMP_W = 4;

  // Function codes of an input item.
  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef struct packed {
    logic               func;
    logic signed [31:0] element_value;
    logic signed [31:0] target_value;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [8:0] position;
    logic [3:0] comparisons;
    logic       overflowed;
  } out_item_t;

  // Result handed from the engine to the output buffer.
  typedef struct packed {
    logic      load;
    out_item_t item;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_RESULT
  } state_e;

endpackage

@@ design/sbs_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module sbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/sbs_engine.sv @@
// Insertion and binary search sequencer around the sorted element store.
// Depends on sbs_pkg, sbs_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbs_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sbs_pkg::in_item_t in_item_i,
  input  logic             can_load_i,
  output sbs_pkg::res_t    res_o
);

  sbs_pkg::state_e state_q, state_d;

  logic [sbs_pkg::CNT_W-1:0]  count_q, count_d;
  logic                       ovf_q, ovf_d;
  logic [sbs_pkg::CNT_W-1:0]  p_q, p_d;
  logic signed [31:0]         val_q, val_d;
  logic [sbs_pkg::CNT_W-1:0]  left_q, left_d;
  logic [sbs_pkg::CNT_W-1:0]  hi_q, hi_d;
  logic [sbs_pkg::ADDR_W-1:0] mid_q, mid_d;
  logic [sbs_pkg::CMP_W-1:0]  probes_q, probes_d;
  logic                       found_q, found_d;
  logic [sbs_pkg::POS_W-1:0]  pos_q, pos_d;

  logic                       ram_we;
  logic [sbs_pkg::ADDR_W-1:0] ram_waddr;
  logic [31:0]                ram_wdata;
  logic [sbs_pkg::ADDR_W-1:0] ram_raddr;
  logic [31:0]                ram_rdata;
  logic signed [31:0]         rdata;

  logic                       accept;
  logic                       is_full;
  logic [sbs_pkg::CNT_W-1:0]  p_m1;
  logic [sbs_pkg::CNT_W-1:0]  p_m2;
  logic                       do_shift;
  logic [sbs_pkg::CNT_W-1:0]  span;
  logic [sbs_pkg::CNT_W-1:0]  mid_full;
  logic [sbs_pkg::CNT_W-1:0]  mid_ext;
  logic [sbs_pkg::CNT_W-1:0]  mid_p1;
  logic                       cmp_eq;
  logic                       cmp_lt;
  logic                       keep_search;

  // Element store.
  sbs_ram #(
    .WIDTH(sbs_pkg::DATA_W),
    .DEPTH(sbs_pkg::MAX_ELEMENTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Shared decode of the current step.
  assign rdata = $signed(ram_rdata);
  assign accept = in_valid_i && !in_stall_o;
  assign is_full = (count_q == sbs_pkg::CNT_W'(sbs_pkg::MAX_ELEMENTS));
  assign p_m1 = p_q - sbs_pkg::CNT_W'(1);
  assign p_m2 = p_q - sbs_pkg::CNT_W'(2);
  assign do_shift = (p_q != '0) && (rdata > val_q);
  assign span = hi_q - sbs_pkg::CNT_W'(1) - left_q;
  assign mid_full = left_q + (span >> 1);
  assign mid_ext = sbs_pkg::CNT_W'(mid_q);
  assign mid_p1 = mid_ext + sbs_pkg::CNT_W'(1);
  assign cmp_eq = (rdata == val_q);
  assign cmp_lt = (rdata < val_q);
  assign keep_search = cmp_lt ? (mid_p1 < hi_q) : (left_q < mid_ext);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sbs_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_item_i.func == sbs_pkg::FUNC_ADD) begin
            if (!is_full) begin
              state_d = sbs_pkg::ST_INS_RD;
            end
          end else if (count_q == '0) begin
            state_d = sbs_pkg::ST_RESULT;
          end else begin
            state_d = sbs_pkg::ST_SRCH_RD;
          end
        end
      end
      sbs_pkg::ST_INS_RD: begin
        state_d = sbs_pkg::ST_INS_CMP;
      end
      sbs_pkg::ST_INS_CMP: begin
        if (!do_shift) begin
          state_d = sbs_pkg::ST_IDLE;
        end
      end
      sbs_pkg::ST_SRCH_RD: begin
        state_d = sbs_pkg::ST_SRCH_CMP;
      end
      sbs_pkg::ST_SRCH_CMP: begin
        if (cmp_eq || !keep_search) begin
          state_d = sbs_pkg::ST_RESULT;
        end else begin
          state_d = sbs_pkg::ST_SRCH_RD;
        end
      end
      sbs_pkg::ST_RESULT: begin
        if (can_load_i) begin
          state_d = sbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sbs_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory controls, handshake and datapath updates.
  always_comb begin
    in_stall_o = (state_q != sbs_pkg::ST_IDLE);
    ram_we = 1'b0;
    ram_waddr = p_q[sbs_pkg::ADDR_W-1:0];
    ram_wdata = rdata;
    ram_raddr = p_m1[sbs_pkg::ADDR_W-1:0];
    res_o.load = 1'b0;
    res_o.item.found = found_q;
    res_o.item.position = pos_q;
    res_o.item.comparisons = probes_q;
    res_o.item.overflowed = ovf_q;
    count_d = count_q;
    ovf_d = ovf_q;
    p_d = p_q;
    val_d = val_q;
    left_d = left_q;
    hi_d = hi_q;
    mid_d = mid_q;
    probes_d = probes_q;
    found_d = found_q;
    pos_d = pos_q;
    case (state_q)
      sbs_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_item_i.func == sbs_pkg::FUNC_ADD) begin
            if (is_full) begin
              ovf_d = 1'b1;
            end else begin
              p_d = count_q;
              val_d = in_item_i.element_value;
            end
          end else begin
            val_d = in_item_i.target_value;
            left_d = '0;
            hi_d = count_q;
            probes_d = '0;
            found_d = 1'b0;
            pos_d = '0;
          end
        end
      end
      sbs_pkg::ST_INS_RD: begin
        // Fetch the entry just below the insertion point.
        ram_raddr = p_m1[sbs_pkg::ADDR_W-1:0];
      end
      sbs_pkg::ST_INS_CMP: begin
        ram_we = 1'b1;
        if (do_shift) begin
          // Move the larger entry up one slot and fetch the next one down.
          ram_wdata = rdata;
          ram_raddr = p_m2[sbs_pkg::ADDR_W-1:0];
          p_d = p_m1;
        end else begin
          ram_wdata = val_q;
          count_d = count_q + sbs_pkg::CNT_W'(1);
        end
      end
      sbs_pkg::ST_SRCH_RD: begin
        ram_raddr = mid_full[sbs_pkg::ADDR_W-1:0];
        mid_d = mid_full[sbs_pkg::ADDR_W-1:0];
        probes_d = probes_q + sbs_pkg::CMP_W'(1);
      end
      sbs_pkg::ST_SRCH_CMP: begin
        if (cmp_eq) begin
          found_d = 1'b1;
          pos_d = sbs_pkg::POS_W'(mid_p1);
        end else if (cmp_lt) begin
          left_d = mid_p1;
        end else begin
          hi_d = mid_ext;
        end
      end
      sbs_pkg::ST_RESULT: begin
        res_o.load = can_load_i;
        if (can_load_i) begin
          // A query empties the set once its result is handed on.
          count_d = '0;
          ovf_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbs_pkg::ST_IDLE;
      count_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q <= ovf_d;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    val_q <= val_d;
    left_q <= left_d;
    hi_q <= hi_d;
    mid_q <= mid_d;
    probes_q <= probes_d;
    found_q <= found_d;
    pos_q <= pos_d;
  end

  `SBS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= sbs_pkg::CNT_W'(sbs_pkg::MAX_ELEMENTS))
  `SBS_ASSERT(a_search_window, clk_i, rst_ni, (state_q != sbs_pkg::ST_SRCH_RD) || ((left_q < hi_q) && (hi_q <= count_q)))
  `SBS_ASSERT(a_insert_room, clk_i, rst_ni, (state_q != sbs_pkg::ST_INS_CMP) || (p_q <= count_q && !is_full))
  `SBS_ASSERT_NEXT(a_query_clears, clk_i, rst_ni, res_o.load, (count_q == '0) && !ovf_q && (state_q == sbs_pkg::ST_IDLE))

endmodule

@@ design/sbs_outbuf.sv @@
// Output register that holds one result item until the receiver takes it.
// Depends on sbs_pkg.
`timescale 1ns / 1ps

module sbs_outbuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sbs_pkg::res_t      res_i,
  output logic               can_load_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sbs_pkg::out_item_t out_item_o
);

  logic               valid_q, valid_d;
  sbs_pkg::out_item_t item_q, item_d;

  // A new result may enter when the register is empty or being drained.
  assign can_load_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    item_d = item_q;
    if (res_i.load) begin
      valid_d = 1'b1;
      item_d = res_i.item;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign out_valid_o = valid_q;
  assign out_item_o = item_q;

endmodule

@@ design/sorted_binary_search.sv @@
// Sorted binary search block: keeps signed elements in order and searches them.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i): an item with func add
//   inserts element_value in ascending order; an item with func search looks
//   for target_value, returns one result item and then empties the set.
//   Output channel (out_valid_o / out_stall_i / out_item_o): one result item per
//   search with found, 1-based position, probe count and the overflow flag.
//   An add to a full store drops the element, sets the overflow flag, gives no
//   result and is finished in the cycle it is taken.
// Timing: the block takes one item at a time. An add holds the input stalled
//   for a read below the insertion point, then a compare and shift on the
//   single store memory for each of the k stored entries (up to 255) larger
//   than the new element, and then its write. A search stalls the input for
//   a read and a compare per probe (up to 9 probes), then until the output register takes its result.
// Reset: the set and the overflow flag are emptied at once; store contents are
//   not cleared. A stalled result waits in the output register; the next item
//   is still taken, and a following search waits only to hand on its result.
// Depends on sbs_pkg, sbs_engine, sbs_outbuf and sbs_ram.
`timescale 1ns / 1ps

module sorted_binary_search (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sbs_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sbs_pkg::out_item_t out_item_o
);

  sbs_pkg::res_t res;
  logic          can_load;

  // Insertion and search sequencer with the element store.
  sbs_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .can_load_i(can_load),
    .res_o     (res)
  );

  // Result register toward the receiver.
  sbs_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .can_load_o (can_load),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule
